// ===== hdl/slfb_pkg.sv =====
`default_nettype none

package slfb_pkg;

  // input beat layout widths
  localparam int IN_TDATA_W = 56;
  localparam int IN_TUSER_W = 3;

  localparam int FRAME_LEN       = 10;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0]  HOLD_RESET = 8'd8;
  localparam logic [13:0] RECIP10    = 14'd6554;  // 2^16 / 10, rounded up

  typedef enum logic [2:0] {
    REQ_INIT      = 3'd0,
    REQ_BLINK_OFF = 3'd1,
    REQ_BLINK_ON  = 3'd2,
    REQ_CLEAR     = 3'd3,
    REQ_PUT_CHAR  = 3'd4,
    REQ_PUT_STR   = 3'd5,
    REQ_PUT_DEC   = 3'd6
  } req_t;

  typedef logic [3:0][6:0] seg_arr_t;

  // one queued frame: fixed init frame, or a display update
  typedef struct packed {
    logic     init;
    logic     blink;
    seg_arr_t digits;
  } frm_t;

  localparam logic [6:0] SEG_DASH  = 7'h10;
  localparam logic [6:0] SEG_BLANK = 7'h00;

  localparam logic [6:0] SEG_TABLE [40] = '{
    7'h6F, 7'h03, 7'h5D, 7'h57, 7'h33, 7'h76, 7'h7E, 7'h43, 7'h7F, 7'h77,
    7'h10, 7'h04, 7'h00,
    7'h7B, 7'h3E, 7'h6C, 7'h1F, 7'h7C, 7'h78, 7'h77, 7'h3B, 7'h02, 7'h0F,
    7'h38, 7'h2C, 7'h5A, 7'h1A, 7'h6F, 7'h79, 7'h75, 7'h18, 7'h76, 7'h3C,
    7'h0E, 7'h2F, 7'h4E, 7'h2B, 7'h37, 7'h5D, 7'h71
  };

  localparam logic [7:0] INIT_FRAME [FRAME_LEN] = '{
    8'hCD, 8'h80, 8'hE0, 8'hF8, 8'h70, 8'h05, 8'hD5, 8'h9B, 8'hFF, 8'h00
  };

  // ascii code to segment pattern
  function automatic logic [6:0] char_seg(input logic [7:0] c);
    logic [5:0] idx;
    if (c >= 8'h61 && c <= 8'h7A) begin
      idx = 6'(c - 8'h61 + 8'd13);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      idx = 6'(c - 8'h41 + 8'd13);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      idx = 6'(c - 8'h30);
    end else if (c == 8'h2D) begin
      idx = 6'd10;
    end else if (c == 8'h5F) begin
      idx = 6'd11;
    end else if (c == 8'h2A) begin
      idx = 6'd39;
    end else begin
      idx = 6'd12;
    end
    return SEG_TABLE[idx];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/slfb_front.sv =====
`default_nettype none

module slfb_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [slfb_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  wire logic [slfb_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [7:0]                       cfg_data,
  input  wire logic                             q_full,
  output logic                                  q_push,
  output slfb_pkg::frm_t                        q_data
);
  import slfb_pkg::*;

  typedef enum logic {F_IDLE, F_CONV} fstate_t;

  fstate_t     state_r, state_nxt;
  seg_arr_t    digits_r, digits_nxt;
  logic        blink_r, blink_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [7:0]  hold_upd_r;
  logic [13:0] mag_r, mag_nxt;
  logic [1:0]  p_r, p_nxt;
  logic        neg_r, neg_nxt;
  seg_arr_t    tdig_r, tdig_nxt;

  logic        accept;
  logic [1:0]  position;
  logic [7:0]  chr [4];
  logic        timed;
  logic signed [15:0] val, vcl;
  logic [15:0] magabs;
  logic [27:0] prod;
  logic [9:0]  q10;
  logic [13:0] rem_w;
  logic [3:0]  rem;
  seg_arr_t    tdig_tmp;
  seg_arr_t    str_seg;
  logic        upd;
  logic        init_sel;
  logic        done;

  assign in_tready = (state_r == F_IDLE) && !q_full;
  assign accept    = in_tvalid && in_tready;

  // field unpack
  assign position = in_tdata[1:0];
  assign chr[0]   = in_tdata[9:2];
  assign chr[1]   = in_tdata[17:10];
  assign chr[2]   = in_tdata[25:18];
  assign chr[3]   = in_tdata[33:26];
  assign timed    = in_tdata[34];
  assign val      = in_tdata[50:35];

  // clamp and magnitude
  always_comb begin
    if (val < -16'sd999) begin
      vcl = -16'sd999;
    end else if (val > 16'sd9999) begin
      vcl = 16'sd9999;
    end else begin
      vcl = val;
    end
    magabs = vcl[15] ? 16'(-vcl) : 16'(vcl);
  end

  // string pattern: stops at the first zero character
  always_comb begin
    logic go;
    go = 1'b1;
    for (int i = 0; i < 4; i++) begin
      go = go && (chr[i] != 8'h00);
      str_seg[i] = go ? char_seg(chr[i]) : SEG_BLANK;
    end
  end

  // one decimal digit per cycle: divide by ten through the reciprocal
  assign prod  = 28'(mag_r) * 28'(RECIP10);
  assign q10   = prod[25:16];
  assign rem_w = mag_r - 14'({q10, 3'b000}) - 14'({q10, 1'b0});
  assign rem   = rem_w[3:0];

  always_comb begin
    state_nxt  = state_r;
    digits_nxt = digits_r;
    blink_nxt  = blink_r;
    hold_nxt   = hold_r;
    mag_nxt    = mag_r;
    p_nxt      = p_r;
    neg_nxt    = neg_r;
    tdig_nxt   = tdig_r;
    tdig_tmp   = tdig_r;
    upd        = 1'b0;
    init_sel   = 1'b0;
    done       = 1'b0;
    q_push     = 1'b0;

    case (state_r)
      F_IDLE: begin
        if (accept) begin
          case (in_tuser)
            REQ_INIT: begin
              blink_nxt  = 1'b0;
              digits_nxt = '0;
              hold_nxt   = '0;
              init_sel   = 1'b1;
              q_push     = 1'b1;
            end
            REQ_BLINK_OFF: begin
              blink_nxt = 1'b0;
              upd       = 1'b1;
            end
            REQ_BLINK_ON: begin
              blink_nxt = 1'b1;
              upd       = 1'b1;
            end
            REQ_CLEAR: begin
              digits_nxt = '0;
              upd        = 1'b1;
            end
            REQ_PUT_CHAR: begin
              digits_nxt[position] = char_seg(chr[0]);
              upd                  = 1'b1;
            end
            REQ_PUT_STR: begin
              digits_nxt = str_seg;
              upd        = 1'b1;
            end
            REQ_PUT_DEC: begin
              mag_nxt   = magabs[13:0];
              neg_nxt   = vcl[15];
              p_nxt     = 2'd3;
              tdig_nxt  = '0;
              state_nxt = F_CONV;
            end
            default: begin
            end
          endcase
        end
      end
      F_CONV: begin
        tdig_tmp[p_r] = char_seg({4'h3, rem});
        done          = (q10 == 10'd0) || (p_r == 2'd0);
        if (done) begin
          if (neg_r && (p_r != 2'd0)) begin
            tdig_tmp[p_r - 2'd1] = SEG_DASH;
          end
          digits_nxt = tdig_tmp;
          upd        = 1'b1;
          state_nxt  = F_IDLE;
        end else begin
          tdig_nxt = tdig_tmp;
          mag_nxt  = 14'(q10);
          p_nxt    = p_r - 2'd1;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase

    // display update, swallowed while a hold runs
    if (upd) begin
      if (hold_r != 8'd0) begin
        hold_nxt = hold_r - 8'd1;
      end else begin
        q_push = 1'b1;
      end
    end

    if (accept && (in_tuser == REQ_PUT_STR) && timed) begin
      hold_nxt = hold_upd_r;
    end
  end

  assign q_data.init   = init_sel;
  assign q_data.blink  = blink_nxt;
  assign q_data.digits = digits_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      digits_r   <= '0;
      blink_r    <= 1'b0;
      hold_r     <= '0;
      hold_upd_r <= HOLD_RESET;
    end else begin
      state_r  <= state_nxt;
      digits_r <= digits_nxt;
      blink_r  <= blink_nxt;
      hold_r   <= hold_nxt;
      if (cfg_we) begin
        hold_upd_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    p_r    <= p_nxt;
    neg_r  <= neg_nxt;
    tdig_r <= tdig_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/slfb_fifo.sv =====
`default_nettype none

module slfb_fifo #(
  parameter int DEPTH = slfb_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire slfb_pkg::frm_t push_data,
  input  wire logic           pop,
  output slfb_pkg::frm_t      head,
  output logic                empty,
  output logic                full
);
  import slfb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  frm_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign empty   = (cnt_r == CW'(0));
  assign full    = (cnt_r == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/slfb_back.sv =====
`default_nettype none

module slfb_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire slfb_pkg::frm_t q_head,
  output logic                q_pop,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tlast
);
  import slfb_pkg::*;

  localparam logic [3:0] LAST_IDX = 4'(FRAME_LEN - 1);

  logic       act_r, act_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  frm_t       frm_r;
  logic       ov_r, ov_nxt;
  logic [7:0] od_r;
  logic       ol_r;
  logic       load_out;
  logic       at_last;
  logic [7:0] cur_byte;

  // frame byte k: command bytes, then patterns packed behind five zero bits
  always_comb begin
    case (cnt_r)
      4'd0, 4'd1, 4'd2, 4'd3: cur_byte = INIT_FRAME[cnt_r];
      4'd4: cur_byte = frm_r.init ? INIT_FRAME[cnt_r] : {7'b0111000, frm_r.blink};
      4'd5: cur_byte = frm_r.init ? INIT_FRAME[cnt_r] : {5'b00000, frm_r.digits[0][6:4]};
      4'd6: cur_byte = frm_r.init ? INIT_FRAME[cnt_r] :
                       {frm_r.digits[0][3:0], frm_r.digits[1][6:3]};
      4'd7: cur_byte = frm_r.init ? INIT_FRAME[cnt_r] :
                       {frm_r.digits[1][2:0], frm_r.digits[2][6:2]};
      4'd8: cur_byte = frm_r.init ? INIT_FRAME[cnt_r] :
                       {frm_r.digits[2][1:0], frm_r.digits[3][6:1]};
      4'd9: cur_byte = frm_r.init ? INIT_FRAME[cnt_r] : {frm_r.digits[3][0], 7'b0000000};
      default: cur_byte = 8'h00;
    endcase
  end

  assign load_out = act_r && (!ov_r || out_tready);
  assign at_last  = (cnt_r == LAST_IDX);
  assign q_pop    = !q_empty && (!act_r || (load_out && at_last));

  always_comb begin
    act_nxt = act_r;
    cnt_nxt = cnt_r;
    ov_nxt  = ov_r;
    if (load_out) begin
      ov_nxt  = 1'b1;
      cnt_nxt = cnt_r + 4'd1;
      if (at_last) begin
        act_nxt = 1'b0;
      end
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
    if (q_pop) begin
      act_nxt = 1'b1;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      act_r <= act_nxt;
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      frm_r <= q_head;
    end
    if (load_out) begin
      od_r <= cur_byte;
      ol_r <= at_last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

endmodule

`default_nettype wire

// ===== hdl/segment_lcd_frame_builder.sv =====
// path: a frame goes from the front into the frame queue, then into the back's frame
//   register and the output register; put decimal converts one digit per cycle first
// throughput: a frame is ten beats, paced by the byte serializer; requests
//   go one per cycle while the queue has room, put decimal blocks input until converted
// reset: synchronous active-low rst_n blanks the digits, clears blink and hold,
//   loads hold_updates with 8 and empties the frame queue
`default_nettype none

module segment_lcd_frame_builder #(
  parameter int QUEUE_DEPTH = slfb_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // request beat
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [slfb_pkg::IN_TUSER_W-1:0] in_tuser,   // req_type
  // position[1:0], char0[9:2], char1[17:10], char2[25:18], char3[33:26],
  // timed[34], value[50:35], zero fill[55:51]
  input  wire logic [slfb_pkg::IN_TDATA_W-1:0] in_tdata,
  // frame beat
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [7:0]                           out_tdata,  // frame_byte
  output logic                                 out_tlast,
  // hold_updates write
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [7:0]                      cfg_data
);
  import slfb_pkg::*;

  logic q_push, q_pop, q_empty, q_full;
  frm_t q_data, q_head;

  // register write is always taken
  assign cfg_ready = 1'b1;

  // front: runs each command against the display state, queues frames
  slfb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  // frame queue decouples command handling from the byte stream
  slfb_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // back: serializes one frame, one beat per cycle while out_tready is high, through an output register
  slfb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
